>>> rtl/dnsx_pkg.sv
// Package for the DNS response address extractor.
// Holds the sizes, phase and emitter state types, and the structs that pass between the front
// and back parts. No dependencies.
`timescale 1ns / 1ps
package dnsx_pkg;

  localparam int MaxLabels   = 8;
  localparam int LabelBytes  = 8;
  localparam int HeaderBytes = 12;

  localparam int CntW = $clog2(MaxLabels + 1);
  localparam int IdxW = (MaxLabels > 1) ? $clog2(MaxLabels) : 1;

  localparam logic [15:0] PosMax   = 16'hFFFF;
  localparam logic [15:0] TypeA    = 16'd1;
  localparam logic [15:0] TypeCname = 16'd5;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_LBYTES = 3'd2,
    PH_QTAIL  = 3'd3,
    PH_ANS    = 3'd4,
    PH_RDATA  = 3'd5,
    PH_ADDR   = 3'd6,
    PH_IDLE   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE    = 2'd0,
    EM_LABEL   = 2'd1,
    EM_VERDICT = 2'd2
  } emit_state_t;

  typedef struct packed {
    logic [7:0]  len;
    logic [63:0] bytes;
  } label_entry_t;

  // verdict of one message, queued from the parser to the emitter
  typedef struct packed {
    logic [CntW-1:0] total;
    logic            found;
    logic [31:0]     address;
  } job_t;

endpackage

>>> rtl/dnsx_front.sv
// Front part: byte-wise DNS message parser and label store.
// Depends on dnsx_pkg.
`timescale 1ns / 1ps
module dnsx_front import dnsx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_take,
  input  logic [7:0]        msg_byte,
  input  logic              is_final,
  output logic              job_push,
  output job_t              job,
  input  logic [IdxW-1:0]   rd_idx,
  output label_entry_t      rd_entry
);

  phase_t          phase_r, phase_nxt;
  logic [15:0]     pos_r, pos_nxt;
  logic [CntW-1:0] seen_r, seen_nxt;
  logic [7:0]      lleft_r, lleft_nxt;
  logic [31:0]     hshift_r, hshift_nxt;
  logic [3:0]      hcnt_r, hcnt_nxt;
  logic [15:0]     rleft_r, rleft_nxt;
  logic [31:0]     ashift_r, ashift_nxt;
  logic [2:0]      acnt_r, acnt_nxt;
  logic            fname_r, fname_nxt;
  logic            ffound_r, ffound_nxt;
  logic            flong_r, flong_nxt;

  label_entry_t    store_r [MaxLabels];
  logic [IdxW-1:0] wr_idx;
  logic [7:0]      kpos;
  logic            st_len_we, st_byte_we;

  assign wr_idx   = seen_r[IdxW-1:0];
  assign kpos     = store_r[wr_idx].len - lleft_r;
  assign rd_entry = store_r[rd_idx];

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    seen_nxt   = seen_r;
    lleft_nxt  = lleft_r;
    hshift_nxt = hshift_r;
    hcnt_nxt   = hcnt_r;
    rleft_nxt  = rleft_r;
    ashift_nxt = ashift_r;
    acnt_nxt   = acnt_r;
    fname_nxt  = fname_r;
    ffound_nxt = ffound_r;
    flong_nxt  = flong_r;
    st_len_we  = 1'b0;
    st_byte_we = 1'b0;
    if (pos_r == PosMax) flong_nxt = 1'b1;
    unique case (phase_r)
      PH_HEADER: begin
        if ({1'b0, pos_r} + 17'd1 >= 17'(HeaderBytes)) phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (msg_byte == 8'd0) begin
          fname_nxt = 1'b1;
          hcnt_nxt  = 4'd0;
          phase_nxt = PH_QTAIL;
        end else if (seen_r >= CntW'(MaxLabels)) begin
          phase_nxt = PH_IDLE;
        end else begin
          st_len_we = 1'b1;
          lleft_nxt = msg_byte;
          phase_nxt = PH_LBYTES;
        end
      end
      PH_LBYTES: begin
        st_byte_we = (kpos < 8'(LabelBytes));
        lleft_nxt  = lleft_r - 8'd1;
        if (lleft_r == 8'd1) begin
          seen_nxt  = seen_r + CntW'(1);
          phase_nxt = PH_LEN;
        end
      end
      PH_QTAIL: begin
        hcnt_nxt = hcnt_r + 4'd1;
        if (hcnt_r == 4'd3) begin
          hcnt_nxt   = 4'd0;
          hshift_nxt = 32'd0;
          phase_nxt  = PH_ANS;
        end
      end
      PH_ANS: begin
        if (hcnt_r == 4'd2 || hcnt_r == 4'd3 || hcnt_r == 4'd10 || hcnt_r == 4'd11)
          hshift_nxt = {hshift_r[23:0], msg_byte};
        hcnt_nxt = hcnt_r + 4'd1;
        if (hcnt_r == 4'd11) begin
          hcnt_nxt   = 4'd0;
          hshift_nxt = 32'd0;
          if (hshift_r[23:8] == TypeA) begin
            ashift_nxt = 32'd0;
            acnt_nxt   = 3'd0;
            phase_nxt  = PH_ADDR;
          end else if (hshift_r[23:8] == TypeCname) begin
            rleft_nxt = {hshift_r[7:0], msg_byte};
            phase_nxt = ({hshift_r[7:0], msg_byte} == 16'd0) ? PH_ANS : PH_RDATA;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_RDATA: begin
        rleft_nxt = rleft_r - 16'd1;
        if (rleft_r == 16'd1) phase_nxt = PH_ANS;
      end
      PH_ADDR: begin
        ashift_nxt = {ashift_r[23:0], msg_byte};
        acnt_nxt   = acnt_r + 3'd1;
        if (acnt_r == 3'd3) begin
          ffound_nxt = 1'b1;
          phase_nxt  = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (pos_r != PosMax) pos_nxt = pos_r + 16'd1;
  end

  // verdict for the message closed by this byte
  assign job_push    = byte_take && is_final;
  assign job.total   = (fname_nxt && !flong_nxt) ? seen_nxt : '0;
  assign job.found   = ffound_nxt && !flong_nxt;
  assign job.address = (ffound_nxt && !flong_nxt) ? ashift_nxt : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n || job_push) begin
      phase_r  <= PH_HEADER;
      pos_r    <= 16'd0;
      seen_r   <= '0;
      lleft_r  <= 8'd0;
      hshift_r <= 32'd0;
      hcnt_r   <= 4'd0;
      rleft_r  <= 16'd0;
      ashift_r <= 32'd0;
      acnt_r   <= 3'd0;
      fname_r  <= 1'b0;
      ffound_r <= 1'b0;
      flong_r  <= 1'b0;
    end else if (byte_take) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      seen_r   <= seen_nxt;
      lleft_r  <= lleft_nxt;
      hshift_r <= hshift_nxt;
      hcnt_r   <= hcnt_nxt;
      rleft_r  <= rleft_nxt;
      ashift_r <= ashift_nxt;
      acnt_r   <= acnt_nxt;
      fname_r  <= fname_nxt;
      ffound_r <= ffound_nxt;
      flong_r  <= flong_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && st_len_we) begin
      store_r[wr_idx].len   <= msg_byte;
      store_r[wr_idx].bytes <= 64'd0;
    end else if (byte_take && st_byte_we) begin
      store_r[wr_idx].bytes[63 - 8*kpos[2:0] -: 8] <= msg_byte;
    end
  end

endmodule

>>> rtl/dnsx_back.sv
// Back part: emits the label entries, top-level label first, then the verdict.
// Depends on dnsx_pkg; reads the label store of dnsx_front.
`timescale 1ns / 1ps
module dnsx_back import dnsx_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  job_t            job_in,
  output logic            job_take,
  output logic            busy,
  output logic [IdxW-1:0] rd_idx,
  input  label_entry_t    rd_entry,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_kind,
  output logic [2:0]      out_label_position,
  output logic [7:0]      out_label_length,
  output logic [63:0]     out_label_bytes,
  output logic [3:0]      out_label_total,
  output logic            out_found,
  output logic [31:0]     out_address,
  output logic            out_end_of_run
);

  emit_state_t     state_r, state_nxt;
  job_t            job_r;
  logic [IdxW-1:0] idx_r;
  logic [CntW-1:0] entry;
  logic            slot_free, load_label, load_verdict;
  logic            valid_r;

  assign slot_free = !valid_r || !out_stall;
  assign entry     = job_r.total - CntW'(1) - CntW'(idx_r);
  assign rd_idx    = entry[IdxW-1:0];
  assign busy      = (state_r != EM_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EM_IDLE:
        if (job_valid) state_nxt = (job_in.total == '0) ? EM_VERDICT : EM_LABEL;
      EM_LABEL:
        if (slot_free && (CntW'(idx_r) == job_r.total - CntW'(1))) state_nxt = EM_VERDICT;
      EM_VERDICT:
        if (slot_free) state_nxt = EM_IDLE;
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_comb begin
    job_take     = (state_r == EM_IDLE) && job_valid;
    load_label   = (state_r == EM_LABEL) && slot_free;
    load_verdict = (state_r == EM_VERDICT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (job_take) idx_r <= '0;
      else if (load_label) idx_r <= idx_r + IdxW'(1);
      if (load_label || load_verdict) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) job_r <= job_in;
    if (load_label) begin
      out_kind           <= 1'b0;
      out_label_position <= 3'(idx_r);
      out_label_length   <= rd_entry.len;
      out_label_bytes    <= rd_entry.bytes;
      out_label_total    <= 4'(job_r.total);
      out_found          <= 1'b0;
      out_address        <= 32'd0;
      out_end_of_run     <= 1'b0;
    end else if (load_verdict) begin
      out_kind           <= 1'b1;
      out_label_position <= 3'd0;
      out_label_length   <= 8'd0;
      out_label_bytes    <= 64'd0;
      out_label_total    <= 4'(job_r.total);
      out_found          <= job_r.found;
      out_address        <= job_r.address;
      out_end_of_run     <= 1'b1;
    end
  end

  assign out_valid = valid_r;

endmodule

>>> rtl/dns_response_address_extractor_core.sv
// DNS response address extractor, top level. Depends on dnsx_pkg, dnsx_front, dnsx_back.
// Throughput: one message byte per cycle while parsing. After the final byte the input
// stalls until the emitter has issued all labels and the verdict of the message; this takes
// longer under output stall. The verdict is registered in the one-entry queue, then in the
// emitter state, before the first result reaches the output register.
// Reset (rst_n, synchronous, active low) clears parser, queue and output valid;
// the label store is not cleared.
`timescale 1ns / 1ps
module dns_response_address_extractor_core import dnsx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [2:0]  out_label_position,
  output logic [7:0]  out_label_length,
  output logic [63:0] out_label_bytes,
  output logic [3:0]  out_label_total,
  output logic        out_found,
  output logic [31:0] out_address,
  output logic        out_end_of_run
);

  logic            byte_take;
  logic            job_push, job_take, back_busy;
  job_t            job_new, job_r;
  logic            job_v_r;
  logic [IdxW-1:0] rd_idx;
  label_entry_t    rd_entry;

  // The label store has a single bank, so the parser holds off the next
  // message until the queued verdict and its labels are out.
  assign in_stall  = job_v_r || back_busy;
  assign byte_take = in_valid && !in_stall;

  dnsx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_take(byte_take),
    .msg_byte (in_msg_byte),
    .is_final (in_is_final),
    .job_push (job_push),
    .job      (job_new),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  // one-entry queue between parser and emitter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
    end else if (job_push) begin
      job_v_r <= 1'b1;
    end else if (job_take) begin
      job_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) job_r <= job_new;
  end

  dnsx_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (job_v_r),
    .job_in            (job_r),
    .job_take          (job_take),
    .busy              (back_busy),
    .rd_idx            (rd_idx),
    .rd_entry          (rd_entry),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_label_position(out_label_position),
    .out_label_length  (out_label_length),
    .out_label_bytes   (out_label_bytes),
    .out_label_total   (out_label_total),
    .out_found         (out_found),
    .out_address       (out_address),
    .out_end_of_run    (out_end_of_run)
  );

endmodule
